// ===== rtl/core/rsm_pkg.sv =====
package rsm_pkg;

    localparam int MaxRow = 64;
    localparam int IdxW = $clog2(MaxRow);
    localparam int CntW = $clog2(MaxRow + 1);
    localparam int QDepth = 2;

    // Row descriptor passed from the front end to the back end.
    typedef struct packed {
        logic [CntW-1:0] count;
        logic [15:0]     maximum;
        logic            overflow;
        logic            bank;
    } row_desc_t;

    // exp(-k/16) in Q1.16.
    function automatic logic [16:0] frac_lut(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0: v = 17'd65536;
            5'd1: v = 17'd61565;
            5'd2: v = 17'd57835;
            5'd3: v = 17'd54331;
            5'd4: v = 17'd51039;
            5'd5: v = 17'd47947;
            5'd6: v = 17'd45042;
            5'd7: v = 17'd42313;
            5'd8: v = 17'd39750;
            5'd9: v = 17'd37341;
            5'd10: v = 17'd35079;
            5'd11: v = 17'd32954;
            5'd12: v = 17'd30957;
            5'd13: v = 17'd29081;
            5'd14: v = 17'd27319;
            5'd15: v = 17'd25664;
            5'd16: v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-i) in Q1.16.
    function automatic logic [16:0] intp_lut(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0: v = 17'd65536;
            4'd1: v = 17'd24109;
            4'd2: v = 17'd8869;
            4'd3: v = 17'd3263;
            4'd4: v = 17'd1200;
            4'd5: v = 17'd442;
            4'd6: v = 17'd162;
            4'd7: v = 17'd60;
            4'd8: v = 17'd22;
            4'd9: v = 17'd8;
            4'd10: v = 17'd3;
            4'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rsm_ram.sv =====
module rsm_ram #(
    parameter int Width = 16,
    parameter int Depth = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/rsm_front.sv =====
module rsm_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [15:0]              s_logit,
    input  logic                     s_row_end,
    output logic                     wr_en,
    output logic [rsm_pkg::IdxW:0]   wr_addr,
    output logic [15:0]              wr_data,
    output logic                     desc_push,
    output rsm_pkg::row_desc_t       desc,
    input  logic                     desc_full,
    input  logic                     bank_busy
);

    logic [rsm_pkg::CntW-1:0] count_reg, count_next;
    logic [15:0]              max_reg, max_next;
    logic                     ovf_reg, ovf_next;
    logic                     bank_reg, bank_next;
    logic                     take, store;
    logic [15:0]              new_max;

    // Wait while the descriptor queue is full or the bank being filled is still being read by the back end.
    assign s_ready = !desc_full && !bank_busy;
    assign take    = s_valid && s_ready;
    assign store   = take && (count_reg < rsm_pkg::CntW'(rsm_pkg::MaxRow));
    assign new_max = (store && ($signed(s_logit) > $signed(max_reg))) ? s_logit : max_reg;

    assign wr_en   = store;
    assign wr_addr = {bank_reg, count_reg[rsm_pkg::IdxW-1:0]};
    assign wr_data = s_logit;

    // The row descriptor goes out with the closing word.
    assign desc_push     = take && s_row_end;
    assign desc.count    = store ? count_reg + 1'b1 : count_reg;
    assign desc.maximum  = new_max;
    assign desc.overflow = ovf_reg || (take && !store);
    assign desc.bank     = bank_reg;

    always_comb begin
        count_next = count_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        if (desc_push) begin
            count_next = '0;
            max_next   = 16'h8000;
            ovf_next   = 1'b0;
            bank_next  = !bank_reg;
        end else if (take) begin
            count_next = desc.count;
            max_next   = new_max;
            ovf_next   = desc.overflow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            max_reg   <= 16'h8000;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== rtl/core/rsm_queue.sv =====
module rsm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rsm_pkg::row_desc_t push_data,
    output logic               full,
    output logic               pop_valid,
    input  logic               pop,
    output rsm_pkg::row_desc_t pop_data,
    output logic [1:0]         bank_used
);

    rsm_pkg::row_desc_t entry_reg [rsm_pkg::QDepth];
    logic               wptr_reg, rptr_reg;
    logic [1:0]         fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rptr_reg];

    // A bank is in use while a queued row refers to it.
    always_comb begin
        bank_used = 2'b00;
        if (fill_reg != 2'd0) begin
            bank_used[entry_reg[rptr_reg].bank] = 1'b1;
        end
        if (fill_reg == 2'd2) begin
            bank_used[entry_reg[!rptr_reg].bank] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/rsm_back.sv =====
module rsm_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   desc_valid,
    input  rsm_pkg::row_desc_t     desc,
    output logic                   desc_pop,
    output logic [rsm_pkg::IdxW:0] rd_addr,
    input  logic [15:0]            rd_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [15:0]            m_probability,
    output logic                   m_last_of_row,
    output logic                   m_row_overflow
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_E1   = 4'd2;
    localparam logic [3:0] S_E2   = 4'd3;
    localparam logic [3:0] S_E3   = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_NRD  = 4'd6;
    localparam logic [3:0] S_N1   = 4'd7;
    localparam logic [3:0] S_N2   = 4'd8;
    localparam logic [3:0] S_N3   = 4'd9;
    localparam logic [3:0] S_MUL  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]               state_reg, state_next;
    logic [rsm_pkg::CntW-1:0] idx_reg;
    logic                     norm_reg;
    logic [15:0]              d_reg;
    logic [16:0]              frac_reg;
    logic [16:0]              intp_reg;
    logic                     zero_reg;
    logic [16:0]              e_reg;
    logic [22:0]              sum_reg;
    logic [32:0]              rem_reg;
    logic [32:0]              dvd_reg;
    logic [32:0]              quo_reg;
    logic [5:0]               bit_reg;
    logic [49:0]              prod_reg;
    logic                     ovalid_reg;
    logic [15:0]              prob_reg;
    logic                     last_reg;
    logic                     ovf_reg;

    logic [15:0]              d_calc;
    logic [16:0]              fa, fb, frac_calc;
    logic [20:0]              slope;
    logic [33:0]              e_prod;
    logic [16:0]              e_calc;
    logic [22:0]              sum_new;
    logic [33:0]              rem_sh;
    logic [49:0]              rnd;
    logic                     last_item;
    logic                     out_step;

    assign rd_addr   = {desc.bank, idx_reg[rsm_pkg::IdxW-1:0]};
    assign last_item = (idx_reg + 1'b1 == desc.count);
    assign out_step  = (state_reg == S_OUT) && (!ovalid_reg || m_ready);

    // Exponent datapath: difference, linear interpolation, integer scale.
    assign d_calc    = desc.maximum - rd_data;
    assign fa        = rsm_pkg::frac_lut({1'b0, d_reg[7:4]});
    assign fb        = rsm_pkg::frac_lut({1'b0, d_reg[7:4]} + 5'd1);
    assign slope     = 21'(fa - fb) * 21'(d_reg[3:0]) + 21'd8;
    assign frac_calc = fa - 17'(slope >> 4);
    assign e_prod    = intp_reg * frac_reg + 34'd32768;
    assign e_calc    = zero_reg ? 17'd0 : e_prod[32:16];
    assign sum_new   = sum_reg + 23'(e_calc);

    // Restoring divider step for the reciprocal, one quotient bit a cycle.
    assign rem_sh = {rem_reg, dvd_reg[32]};
    assign rnd    = prod_reg + 50'd32768;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (desc_valid) state_next = S_RD;
            S_RD:   state_next = S_E1;
            S_E1:   state_next = S_E2;
            S_E2:   state_next = S_E3;
            S_E3: begin
                if (!norm_reg) begin
                    state_next = last_item ? S_DIV : S_RD;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_DIV:  if (bit_reg == 6'd0) state_next = S_NRD;
            S_NRD:  state_next = S_E1;
            S_MUL:  state_next = S_OUT;
            S_OUT: begin
                if (!ovalid_reg || m_ready) begin
                    state_next = last_item ? S_IDLE : S_NRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign desc_pop = out_step && last_item;

    always_ff @(posedge aclk) begin
        // Datapath registers.
        case (state_reg)
            S_E1: begin
                d_reg    <= d_calc;
            end
            S_E2: begin
                zero_reg <= (d_reg[15:8] >= 8'd12);
                intp_reg <= rsm_pkg::intp_lut(d_reg[11:8]);
                frac_reg <= frac_calc;
            end
            S_E3: begin
                e_reg <= e_calc;
                if (!norm_reg && last_item) begin
                    // Dividend 2^32 + sum/2, shifted in from its top bit.
                    rem_reg <= '0;
                    dvd_reg <= {1'b1, 10'd0, 22'(sum_new >> 1)};
                    quo_reg <= '0;
                end
            end
            S_DIV: begin
                dvd_reg <= {dvd_reg[31:0], 1'b0};
                if (rem_sh >= {11'd0, sum_reg}) begin
                    rem_reg <= 33'(rem_sh - {11'd0, sum_reg});
                    quo_reg <= {quo_reg[31:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[32:0];
                    quo_reg <= {quo_reg[31:0], 1'b0};
                end
            end
            S_MUL: begin
                prod_reg <= e_reg * quo_reg;
            end
            default: begin
            end
        endcase
        if (out_step) begin
            prob_reg <= (rnd[49:16] > 34'd65535) ? 16'hFFFF : rnd[31:16];
            last_reg <= last_item;
            ovf_reg  <= desc.overflow;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            norm_reg   <= 1'b0;
            sum_reg    <= '0;
            bit_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_step) begin
                ovalid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    idx_reg  <= '0;
                    norm_reg <= 1'b0;
                    sum_reg  <= '0;
                end
                S_E3: begin
                    if (!norm_reg) begin
                        sum_reg <= sum_new;
                        if (last_item) begin
                            bit_reg <= 6'd32;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd0) begin
                        idx_reg  <= '0;
                        norm_reg <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!ovalid_reg || m_ready) begin
                        idx_reg    <= idx_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = ovalid_reg;
    assign m_probability  = prob_reg;
    assign m_last_of_row  = last_reg;
    assign m_row_overflow = ovf_reg;

endmodule

// ===== rtl/core/row_softmax_top.sv =====
// Row softmax over signed Q8.8 logits, one logit per input word; the word
// with s_row_end closes the row and releases one Q0.16 probability per stored
// logit, in arrival order. Up to 64 logits are kept per row; later ones are
// dropped and flag every result word of that row with m_row_overflow. Rows
// are buffered in two banks of one RAM, so a new row is accepted while the
// previous one is computed, and input accepts one word per cycle unless both
// banks hold unfinished rows. The back end reads each logit once for the sum,
// runs a bit-serial reciprocal, then reads each logit again for
// normalization.
module row_softmax_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_logit,
    input  logic        s_row_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_probability,
    output logic        m_last_of_row,
    output logic        m_row_overflow
);

    logic                   wr_en;
    logic [rsm_pkg::IdxW:0] wr_addr, rd_addr;
    logic [15:0]            wr_data, rd_data;
    logic                   desc_push, desc_full, desc_valid, desc_pop;
    rsm_pkg::row_desc_t     push_desc, head_desc;
    logic [1:0]             bank_used;
    logic                   cur_bank;

    rsm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_logit(s_logit), .s_row_end(s_row_end),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .desc_push(desc_push), .desc(push_desc),
        .desc_full(desc_full), .bank_busy(bank_used[cur_bank])
    );

    assign cur_bank = wr_addr[rsm_pkg::IdxW];

    rsm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(desc_push), .push_data(push_desc), .full(desc_full),
        .pop_valid(desc_valid), .pop(desc_pop), .pop_data(head_desc),
        .bank_used(bank_used)
    );

    rsm_ram #(.Width(16), .Depth(2 * rsm_pkg::MaxRow)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    rsm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .desc_valid(desc_valid), .desc(head_desc), .desc_pop(desc_pop),
        .rd_addr(rd_addr), .rd_data(rd_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_probability(m_probability), .m_last_of_row(m_last_of_row),
        .m_row_overflow(m_row_overflow)
    );

endmodule

// ===== rtl/core/rsm_checker.sv =====
module rsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_probability,
    input logic        m_last_of_row,
    input logic        m_row_overflow
);

    // A result word that is stalled keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_probability)
            && $stable(m_last_of_row) && $stable(m_row_overflow))
        else $error("result word changed while stalled");

    // No result word right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // Input is ready in the cycle after reset.
    a_rdy: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind row_softmax_top rsm_checker u_rsm_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_probability(m_probability), .m_last_of_row(m_last_of_row),
    .m_row_overflow(m_row_overflow)
);
